// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL, included by prc_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRC_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRC_ASSERT(label, clk, rst, prop, msg)
`define PRC_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types, constants and saturating helpers of the pre-trade risk check.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int SYM_W        = $clog2(SYMBOL_COUNT);
   localparam int SEC_W        = 34;
   // One second is 2^9 * 5^9 ns: drop nine bits, then divide by the odd factor.
   localparam logic [20:0] NS_ODD = 21'd1953125;
   // floor(2^61 / 10^9), applied to timestamp bits [62:31]
   localparam logic [31:0] SEC_RECIP   = 32'd2305843009;
   localparam int          RECIP_SHIFT = 30;
   // Remainder after the estimate stays below five times the odd factor.
   localparam int FIX_W        = 24;
   localparam int QUEUE_DEPTH  = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 63;

   typedef enum logic [2:0] {
      RSN_NONE, RSN_SIZE, RSN_NOTIONAL, RSN_RATE, RSN_POSITION, RSN_LOSS, RSN_DRAWDOWN
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_QTY, CSR_MAX_NOTIONAL, CSR_MAX_RATE, CSR_MAX_POS, CSR_MAX_LOSS, CSR_MAX_DD
   } csr_index_type;

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_REM, F_FIX, F_PUSH} front_state_type;
   typedef enum logic {B_IDLE, B_EXEC} back_state_type;

   typedef struct packed {
      logic [30:0] max_qty;
      logic [62:0] max_notional;
      logic [31:0] max_rate;
      logic [62:0] max_pos;
      logic [62:0] max_loss;
      logic [62:0] max_dd;
   } cfg_type;

   typedef struct packed {
      logic                    kind;
      logic [SYM_W-1:0]        sym;
      logic                    is_sell;
      logic signed [31:0]      qty;
      logic signed [63:0]      product;
      logic [SEC_W-1:0]        second;
      reason_type              reason;
   } job_type;

   typedef struct packed {
      logic push;
   } qctl_type;

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_sub = s[63:0];
      end
   endfunction

endpackage

// ===== hdl/prc_if.sv =====
// ----------------------------------------------------------------------------
// prc_req_if / prc_rsp_if
// Valid/ready channels carrying check requests and their responses.
// ----------------------------------------------------------------------------
interface prc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         symbol_index;
   logic               is_sell;
   logic signed [31:0] quantity;
   logic [31:0]        price_cents;
   logic [62:0]        timestamp_ns;
   modport source (output valid, kind, symbol_index, is_sell, quantity, price_cents,
                   timestamp_ns, input ready);
   modport sink (input valid, kind, symbol_index, is_sell, quantity, price_cents,
                 timestamp_ns, output ready);
endinterface

interface prc_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [2:0]         reject_reason;
   logic signed [63:0] net_position;
   logic signed [63:0] realized_pnl_cents;
   logic [31:0]        approved_total;
   logic [31:0]        rejected_total;
   modport source (output valid, accepted, reject_reason, net_position,
                   realized_pnl_cents, approved_total, rejected_total, input ready);
   modport sink (input valid, accepted, reject_reason, net_position,
                 realized_pnl_cents, approved_total, rejected_total, output ready);
endinterface

// ===== hdl/pretrade_risk_check.sv =====
// ----------------------------------------------------------------------------
// pretrade_risk_check
// Pre-trade order screening with fill-driven position and PnL tracking.
// ----------------------------------------------------------------------------
// An order check passes the front through its multiply, remainder, correction
// and push states, a fill through multiply and push only; the front derives
// the timestamp's whole second by reciprocal multiplication, and the back
// needs a table read and an execute step. The front takes a new request only
// once it has pushed the last one; the back drains the two-entry queue between
// them, and a stalled response stalls the back and, once the queue fills, the
// front. The position table needs no clearing pass: each of the 256 entries
// has a valid bit that reset clears. The user must write limits through the
// csr port only while no request is in flight; the block does not enforce it.
module pretrade_risk_check
   import prc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   prc_req_if.sink               req_ch,
   prc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   qctl_type qctl;
   job_type  push_job, head_job;
   logic     q_full, q_empty, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_qty      <= 31'd1000;
         cfg_ff.max_notional <= 63'd100000000;
         cfg_ff.max_rate     <= 32'd1000;
         cfg_ff.max_pos      <= 63'd10000;
         cfg_ff.max_loss     <= 63'd1000000;
         cfg_ff.max_dd       <= 63'd1000000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_QTY:      cfg_ff.max_qty      <= csr_wdata[30:0];
            CSR_MAX_NOTIONAL: cfg_ff.max_notional <= csr_wdata;
            CSR_MAX_RATE:     cfg_ff.max_rate     <= csr_wdata[31:0];
            CSR_MAX_POS:      cfg_ff.max_pos      <= csr_wdata;
            CSR_MAX_LOSS:     cfg_ff.max_loss     <= csr_wdata;
            CSR_MAX_DD:       cfg_ff.max_dd       <= csr_wdata;
            default: ;
         endcase
      end
   end

   prc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg_ff),
      .qctl_out (qctl),
      .q_full   (q_full),
      .job_out  (push_job)
   );

   prc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (qctl.push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   prc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_job (head_job),
      .empty    (q_empty),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== hdl/prc_front.sv =====
// ----------------------------------------------------------------------------
// prc_front
// Takes requests, forms the notional or fill value, derives the whole second
// of order timestamps by reciprocal multiplication, screens size and notional.
// ----------------------------------------------------------------------------
module prc_front
   import prc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   prc_req_if.sink     req_ch,
   input  cfg_type     cfg,
   output qctl_type    qctl_out,
   input  logic        q_full,
   output job_type     job_out
);

   front_state_type    state_ff, state_in;
   logic               kind_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic               sell_ff;
   logic signed [31:0] qty_ff;
   logic [31:0]        price_ff;
   logic [62:0]        ts_ff;
   logic signed [63:0] prod_ff;
   logic [SEC_W-1:0]   est_ff;
   logic [FIX_W-1:0]   rem_ff;
   logic [SEC_W-1:0]   quo_ff;
   logic               take;
   logic signed [65:0] prod_full;
   logic [63:0]        recip_full;
   logic [54:0]        back_full;
   logic [2:0]         fix_cnt;
   reason_type         reason;

   assign take = req_ch.valid && req_ch.ready;
   assign prod_full = qty_ff * $signed({1'b0, price_ff});
   // Estimate falls short of the true second by at most four.
   assign recip_full = 64'(ts_ff[62:31]) * 64'(SEC_RECIP);
   assign back_full  = 55'(est_ff) * 55'(NS_ODD);
   assign fix_cnt    = 3'(rem_ff >= FIX_W'(NS_ODD)) + 3'(rem_ff >= FIX_W'(2 * NS_ODD))
                     + 3'(rem_ff >= FIX_W'(3 * NS_ODD)) + 3'(rem_ff >= FIX_W'(4 * NS_ODD));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (take) state_in = F_MUL;
         F_MUL:   state_in = kind_ff ? F_PUSH : F_REM;
         F_REM:   state_in = F_FIX;
         F_FIX:   state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready  = (state_ff == F_IDLE);
      qctl_out.push = (state_ff == F_PUSH) && !q_full;
   end

   always_comb begin
      if (qty_ff[31] || qty_ff == 32'sd0 || qty_ff[30:0] > cfg.max_qty) begin
         reason = RSN_SIZE;
      end else if (prod_ff[62:0] > cfg.max_notional) begin
         reason = RSN_NOTIONAL;
      end else begin
         reason = RSN_NONE;
      end
      job_out.kind    = kind_ff;
      job_out.sym     = sym_ff;
      job_out.is_sell = sell_ff;
      job_out.qty     = qty_ff;
      job_out.product = prod_ff;
      job_out.second  = quo_ff;
      job_out.reason  = reason;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= req_ch.kind;
         sym_ff   <= req_ch.symbol_index[SYM_W-1:0];
         sell_ff  <= req_ch.is_sell;
         qty_ff   <= req_ch.quantity;
         price_ff <= req_ch.price_cents;
         ts_ff    <= req_ch.timestamp_ns;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= prod_full[63:0];
         est_ff  <= recip_full[63:RECIP_SHIFT];
      end
      if (state_ff == F_REM) begin
         rem_ff <= FIX_W'(55'(ts_ff[62:9]) - back_full);
      end
      // Step the estimate up by the multiples of the divisor still left over.
      if (state_ff == F_FIX) begin
         quo_ff <= est_ff + SEC_W'(fix_cnt);
      end
   end

endmodule

// ===== hdl/prc_queue.sv =====
// ----------------------------------------------------------------------------
// prc_queue
// Short job queue between the screening front and the executing back.
// ----------------------------------------------------------------------------
module prc_queue
   import prc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [PTR_W:0]     count_ff;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

// ===== hdl/prc_back.sv =====
// ----------------------------------------------------------------------------
// prc_back
// Executes jobs: rate window, position and PnL checks, fill updates, and the
// response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module prc_back
   import prc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  job_type head_job,
   input  logic    empty,
   output logic    pop,
   prc_rsp_if.source rsp_ch
);

   back_state_type     state_ff, state_in;
   job_type            job_ff;
   logic signed [63:0] pos_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] vld_ff;
   logic signed [63:0] rd_ff;
   logic               rdv_ff;
   logic signed [63:0] pnl_ff, peak_ff;
   logic [SEC_W-1:0]   win_ff;
   logic [31:0]        cnt_ff, appr_ff, rej_ff;
   logic               rsp_valid_ff;
   logic               acc_ff;
   reason_type         reason_ff;
   logic signed [63:0] npos_ff, opnl_ff;

   logic               out_free;
   logic signed [63:0] pos, qty64, moved, pnl_next;
   logic [31:0]        seen;
   logic [63:0]        mag, drawdown;
   reason_type         reason;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!empty && out_free) state_in = B_EXEC;
         B_EXEC:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == B_IDLE) && !empty && out_free;
   end

   always_comb begin
      pos      = rdv_ff ? rd_ff : 64'sd0;
      qty64    = 64'(job_ff.qty);
      moved    = job_ff.is_sell ? sat_sub(pos, qty64) : sat_add(pos, qty64);
      pnl_next = job_ff.is_sell ? sat_add(pnl_ff, job_ff.product)
                                : sat_sub(pnl_ff, job_ff.product);
      seen     = (job_ff.second != win_ff) ? 32'd0 : cnt_ff;
      mag      = moved[63] ? (64'd0 - 64'(moved)) : 64'(moved);
      drawdown = 64'(peak_ff) - 64'(pnl_ff);
      if (job_ff.reason != RSN_NONE) begin
         reason = job_ff.reason;
      end else if (seen >= cfg.max_rate) begin
         reason = RSN_RATE;
      end else if (mag > {1'b0, cfg.max_pos}) begin
         reason = RSN_POSITION;
      end else if ($signed({pnl_ff[63], pnl_ff}) < -$signed({2'b00, cfg.max_loss})) begin
         reason = RSN_LOSS;
      end else if (peak_ff >= pnl_ff && drawdown > {1'b0, cfg.max_dd}) begin
         reason = RSN_DRAWDOWN;
      end else begin
         reason = RSN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         vld_ff       <= '0;
         pnl_ff       <= '0;
         peak_ff      <= '0;
         win_ff       <= '0;
         cnt_ff       <= '0;
         appr_ff      <= '0;
         rej_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == B_EXEC) begin
            rsp_valid_ff <= 1'b1;
            if (job_ff.kind) begin
               vld_ff[job_ff.sym] <= 1'b1;
               pnl_ff <= pnl_next;
               if (pnl_next > peak_ff) peak_ff <= pnl_next;
            end else begin
               // Only orders that clear size and notional touch the window.
               if (job_ff.reason == RSN_NONE) begin
                  win_ff <= job_ff.second;
                  cnt_ff <= (seen == 32'hFFFF_FFFF) ? seen : seen + 32'd1;
               end
               if (reason == RSN_NONE) begin
                  appr_ff <= appr_ff + 32'd1;
               end else begin
                  rej_ff <= rej_ff + 32'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
         rd_ff  <= pos_mem[head_job.sym];
         rdv_ff <= vld_ff[head_job.sym];
      end
      if (state_ff == B_EXEC && job_ff.kind) begin
         pos_mem[job_ff.sym] <= moved;
      end
      if (state_ff == B_EXEC) begin
         acc_ff    <= job_ff.kind || (reason == RSN_NONE);
         reason_ff <= job_ff.kind ? RSN_NONE : reason;
         npos_ff   <= job_ff.kind ? moved : pos;
         opnl_ff   <= job_ff.kind ? pnl_next : pnl_ff;
      end
   end

   always_comb begin
      rsp_ch.valid              = rsp_valid_ff;
      rsp_ch.accepted           = acc_ff;
      rsp_ch.reject_reason      = reason_ff;
      rsp_ch.net_position       = npos_ff;
      rsp_ch.realized_pnl_cents = opnl_ff;
      // Counters lag by nothing: they move in the same edge as the response.
      rsp_ch.approved_total     = appr_ff;
      rsp_ch.rejected_total     = rej_ff;
   end

   `PRC_ASSERT(a_exec_loads_rsp, clock, reset, state_ff == B_EXEC |=> rsp_valid_ff, "no response")
   `PRC_ASSERT(a_reason_ok, clock, reset, rsp_valid_ff |-> (acc_ff == (reason_ff == RSN_NONE)), "flag")
   `PRC_NEVER(a_pop_busy, clock, reset, pop && rsp_valid_ff && !rsp_ch.ready, "pop while blocked")
   `PRC_ASSERT(a_peak_holds, clock, reset, 1'b1 |=> (peak_ff >= pnl_ff || $past(peak_ff < pnl_ff)), "peak")

endmodule

// ===== test/tb_pretrade_risk_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pretrade_risk_check
// Self-checking bench for the pre-trade risk check. A behavioral predictor of
// the limit checks, rate window, position book and PnL tracking builds one
// expected response per request transfer; responses are compared in order.
// Directed tests cover every reject reason but drawdown, and the saturation corners;
// random phases run under several limit sets, most with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_pretrade_risk_check;
   import prc_pkg::*;

   localparam int LIMIT_CYCLES = 900000;
   localparam logic signed [64:0] S64_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] S64_MIN = -65'sh1_0000_0000_0000_0000 >>> 1;
   localparam logic [62:0] ALL63 = {63{1'b1}};

   typedef struct {
      logic              accepted;
      reason_type        reason;
      logic signed [63:0] position;
      logic signed [63:0] pnl;
      logic [31:0]       approvals;
      logic [31:0]       rejections;
   } verdict_type;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   prc_req_if req_ch ();
   prc_rsp_if rsp_ch ();

   pretrade_risk_check dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [30:0] lim_qty;
   logic [62:0] lim_notional, lim_pos, lim_loss, lim_dd;
   logic [31:0] lim_rate;
   logic signed [63:0] book [SYMBOL_COUNT];
   logic signed [63:0] pnl_now, pnl_high;
   logic [33:0] cur_second;
   logic [31:0] second_count, n_approved, n_rejected;

   verdict_type pending_verdicts[$];
   int mismatches = 0;
   int cycles = 0;
   bit no_idle = 0;
   logic [62:0] ts_now = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic signed [63:0] clamp(logic signed [64:0] w);
      if (w > S64_MAX) return S64_MAX[63:0];
      if (w < S64_MIN) return S64_MIN[63:0];
      return w[63:0];
   endfunction

   function automatic reason_type screen_order(int sym, logic sell,
                                               logic signed [31:0] qty,
                                               logic [31:0] price, logic [62:0] ts);
      logic [63:0] notional, mag, drop;
      logic [33:0] sec;
      logic [31:0] seen;
      logic signed [63:0] proj;
      if (qty <= 0 || {1'b0, qty} > {2'b0, lim_qty}) return RSN_SIZE;
      notional = {32'd0, qty} * {32'd0, price};
      if (notional > {1'b0, lim_notional}) return RSN_NOTIONAL;
      sec = 34'({1'b0, ts} / 64'd1000000000);
      if (sec != cur_second) begin
         second_count = 0;
         cur_second = sec;
      end
      seen = second_count;
      if (second_count != 32'hFFFF_FFFF) second_count++;
      if (seen >= lim_rate) return RSN_RATE;
      proj = sell ? clamp({book[sym][63], book[sym]} - 65'(qty))
                  : clamp({book[sym][63], book[sym]} + 65'(qty));
      mag = proj[63] ? 64'd0 - proj : proj;
      if (mag > {1'b0, lim_pos}) return RSN_POSITION;
      if ($signed({pnl_now[63], pnl_now}) < -$signed({2'b0, lim_loss})) return RSN_LOSS;
      drop = pnl_high - pnl_now;
      if (pnl_high >= pnl_now && drop > {1'b0, lim_dd}) return RSN_DRAWDOWN;
      return RSN_NONE;
   endfunction

   function automatic verdict_type apply_request(logic kind, logic [7:0] sym,
                                                 logic sell, logic signed [31:0] qty,
                                                 logic [31:0] price, logic [62:0] ts);
      verdict_type v;
      logic signed [63:0] q64, p64, fill_value;
      v.accepted = 1;
      v.reason = RSN_NONE;
      if (!kind) begin
         v.reason = screen_order(sym, sell, qty, price, ts);
         if (v.reason == RSN_NONE) n_approved++;
         else begin
            v.accepted = 0;
            n_rejected++;
         end
      end else begin
         q64 = qty;
         p64 = $signed({32'd0, price});
         fill_value = q64 * p64;
         if (sell) begin
            book[sym] = clamp({book[sym][63], book[sym]} - 65'(q64));
            pnl_now = clamp({pnl_now[63], pnl_now} + {fill_value[63], fill_value});
         end else begin
            book[sym] = clamp({book[sym][63], book[sym]} + 65'(q64));
            pnl_now = clamp({pnl_now[63], pnl_now} - {fill_value[63], fill_value});
         end
         if (pnl_now > pnl_high) pnl_high = pnl_now;
      end
      v.position = book[sym];
      v.pnl = pnl_now;
      v.approvals = n_approved;
      v.rejections = n_rejected;
      return v;
   endfunction

   // one request transfer; valid is only lowered when a gap is taken
   task automatic send(logic kind, logic [7:0] sym, logic sell, logic signed [31:0] qty,
                       logic [31:0] price, logic [62:0] ts);
      if (!no_idle && $urandom_range(99) < 21) begin
         req_ch.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 21);
      end
      req_ch.valid <= 1;
      req_ch.kind <= kind;
      req_ch.symbol_index <= sym;
      req_ch.is_sell <= sell;
      req_ch.quantity <= qty;
      req_ch.price_cents <= price;
      req_ch.timestamp_ns <= ts;
      do @(posedge clock); while (!req_ch.ready);
      pending_verdicts.push_back(apply_request(kind, sym, sell, qty, price, ts));
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      wait (pending_verdicts.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_limit(csr_index_type idx, logic [62:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MAX_QTY:      lim_qty = value[30:0];
         CSR_MAX_NOTIONAL: lim_notional = value;
         CSR_MAX_RATE:     lim_rate = value[31:0];
         CSR_MAX_POS:      lim_pos = value;
         CSR_MAX_LOSS:     lim_loss = value;
         CSR_MAX_DD:       lim_dd = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(logic [62:0] q, logic [62:0] n, logic [62:0] r,
                             logic [62:0] p, logic [62:0] l, logic [62:0] d);
      drain();
      write_limit(CSR_MAX_QTY, q);
      write_limit(CSR_MAX_NOTIONAL, n);
      write_limit(CSR_MAX_RATE, r);
      write_limit(CSR_MAX_POS, p);
      write_limit(CSR_MAX_LOSS, l);
      write_limit(CSR_MAX_DD, d);
      csr_we <= 0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_ch.accepted !== want.accepted || rsp_ch.reject_reason !== want.reason
                   || rsp_ch.net_position !== want.position
                   || rsp_ch.realized_pnl_cents !== want.pnl
                   || rsp_ch.approved_total !== want.approvals
                   || rsp_ch.rejected_total !== want.rejections) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch %0d: exp acc=%0d rsn=%0d pos=%0d pnl=%0d ap=%0d rj=%0d",
                        cycles, want.accepted, want.reason, want.position, want.pnl,
                        want.approvals, want.rejections);
                     $display(" got acc=%0d rsn=%0d pos=%0d pnl=%0d ap=%0d rj=%0d",
                        rsp_ch.accepted, rsp_ch.reject_reason, rsp_ch.net_position,
                        rsp_ch.realized_pnl_cents, rsp_ch.approved_total,
                        rsp_ch.rejected_total);
                  end
               end
            end
         end
         rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);
      end
   end

   task automatic test_each_reason();
      send(0, 8'd0, 0, 32'sd0, 32'd100, 63'd0);                 // zero size
      send(0, 8'd1, 1, -32'sd5, 32'd100, 63'd0);                // negative size
      send(0, 8'd2, 0, 32'sh8000_0000, 32'd1, 63'd5);          // most negative size
      send(0, 8'd3, 0, 32'sd1001, 32'd1, 63'd10);              // one above limit
      send(0, 8'd4, 0, 32'sd1000, 32'd100001, 63'd20);         // notional
      send(0, 8'd5, 0, 32'sd1000, 32'd100000, 63'd30);         // notional at limit
      send(1, 8'd255, 0, 32'sd9500, 32'd10, 63'd0);            // fill, buy
      send(0, 8'd255, 0, 32'sd600, 32'd0, 63'd40);             // position
      send(0, 8'd255, 1, 32'sd600, 32'hFFFF_FFFF, 63'd50);     // price max, notional
      send(1, 8'd7, 1, 32'sd100, 32'd50000, 63'h7FFF_FFFF_FFFF_FFFF); // sell fill
      send(0, 8'd7, 1, 32'sd10, 32'd1, 63'd60);
      send(1, 8'd7, 0, 32'sd100, 32'd70000, 63'd0);            // loss below zero
      send(0, 8'd7, 0, 32'sd10, 32'd1, 63'd70);                // loss
      send(1, 8'd8, 0, 32'sd1000, 32'd2000000, 63'd0);         // deep loss
      send(0, 8'd8, 1, 32'sd1, 32'd1, 63'd80);                 // loss
   endtask

   task automatic test_rate_window();
      set_limits(1000, 100000000, 2, 10000, ALL63, ALL63);
      for (int i = 0; i < 5; i++) send(0, 8'd9, 0, 32'sd1, 32'd1, 63'd3_000_000_000 + i);
      send(0, 8'd9, 0, 32'sd0, 32'd1, 63'd3_000_000_100);     // size reject not counted
      send(0, 8'd9, 0, 32'sd1, 32'd1, 63'd4_000_000_000);     // new second
      send(0, 8'd9, 0, 32'sd1, 32'd1, 63'd0);                 // timestamp zero
      send(0, 8'd9, 0, 32'sd1, 32'd1, 63'h7FFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_saturation();
      set_limits({63{1'b1}}, ALL63, 32'hFFFF_FFFF, ALL63, ALL63, ALL63);
      send(0, 8'd10, 0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 63'd1);
      send(1, 8'd11, 0, 32'sh8000_0000, 32'hFFFF_FFFF, 63'd0); // buy, negative qty
      send(1, 8'd11, 0, 32'sh8000_0000, 32'hFFFF_FFFF, 63'd0); // pnl saturates high
      send(1, 8'd12, 1, 32'sh8000_0000, 32'hFFFF_FFFF, 63'd0);
      send(1, 8'd12, 1, 32'sh8000_0000, 32'hFFFF_FFFF, 63'd0);
      send(1, 8'd12, 1, 32'sh8000_0000, 32'hFFFF_FFFF, 63'd0); // pnl saturates low
      send(0, 8'd12, 1, 32'sh7FFF_FFFF, 32'd1, 63'd2);
      set_limits(0, 0, 0, 0, 0, 0);
      send(0, 8'd13, 0, 32'sd1, 32'd0, 63'd3);
      send(1, 8'd13, 1, 32'sd1, 32'd0, 63'd3);
   endtask

   task automatic random_item();
      logic kind, sell;
      logic [7:0] sym;
      logic signed [31:0] qty;
      logic [31:0] price;
      int pick;
      kind = ($urandom_range(99) < 35);
      sell = 1'($urandom_range(1));
      sym = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom);
      pick = $urandom_range(99);
      if (kind) qty = (pick < 85) ? $signed(32'($urandom_range(600))) - 32'sd200
                                  : $signed($urandom);
      else if (pick < 80) qty = $urandom_range(1, 1500);
      else if (pick < 90) qty = -$signed(32'($urandom_range(3)));
      else qty = $signed($urandom);
      price = ($urandom_range(99) < 80) ? $urandom_range(200000) : $urandom;
      if ($urandom_range(99) < 4) ts_now = 63'({$urandom, $urandom});
      else ts_now = ts_now + 63'($urandom_range(300_000_000));
      send(kind, sym, sell, qty, price, ts_now);
   endtask

   task automatic test_random(int count, bit randomize_limits);
      if (randomize_limits)
         set_limits($urandom_range(1, 3000), $urandom_range(1000, 1_000_000_000),
                    $urandom_range(1, 20), $urandom_range(100, 20000),
                    $urandom_range(100_000_000), $urandom_range(100_000_000));
      for (int i = 0; i < count; i++) random_item();
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = CSR_MAX_QTY;
      csr_wdata = 0;
      req_ch.valid = 0;
      req_ch.kind = 0;
      req_ch.symbol_index = 0;
      req_ch.is_sell = 0;
      req_ch.quantity = 0;
      req_ch.price_cents = 0;
      req_ch.timestamp_ns = 0;
      rsp_ch.ready = 0;
      lim_qty = 1000;
      lim_notional = 100000000;
      lim_rate = 1000;
      lim_pos = 10000;
      lim_loss = 1000000;
      lim_dd = 1000000;
      foreach (book[i]) book[i] = 0;
      pnl_now = 0;
      pnl_high = 0;
      cur_second = 0;
      second_count = 0;
      n_approved = 0;
      n_rejected = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_each_reason();
      test_rate_window();
      test_saturation();
      set_limits(1000, 100000000, 1000, 10000, 1000000, 1000000);
      test_random(250, 0);
      no_idle = 1;
      test_random(150, 1);
      no_idle = 0;
      test_random(200, 1);
      test_random(200, 1);
      set_limits(ALL63, ALL63, 32'hFFFF_FFFF, ALL63, ALL63, ALL63);
      test_random(100, 0);
      set_limits(0, 0, 0, 0, 0, 0);
      test_random(40, 0);
      drain();

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
